// ===== rtl/lbph_pkg.sv =====
// ----------------------------------------------------------------------------
// lbph_pkg
// Shared types, constants and tap geometry functions for the local binary
// pattern histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lbph_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int RADIUS_DEF = 1;
	localparam int NEIGHBORS_DEF = 8;

	localparam int REG_W = 11;
	localparam logic [REG_W-1:0] DIM_RESET = 11'd1024;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam int COUNT_W = 20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;
	localparam int HIST_BINS = 256;
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_TAPS = 8;

	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_FLUSH = 2'd1,
		CMD_READ  = 2'd2,
		CMD_BAD   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_CODE   = 2'd0,
		KIND_COUNT  = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_STREAM = 2'd0,
		OP_READ   = 2'd1,
		OP_REJECT = 2'd2
	} op_kind_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_kind_t kind;
		logic [7:0] value;
		logic clear;
		logic emit;
		logic last;
		logic [MAX_TAPS-1:0] mask;
	} op_t;

	localparam int COS_Q16 [31] = '{
		65536, 65446, 65177, 64729, 64104, 63303, 62328, 61183,
		59870, 58393, 56756, 54963, 53020, 50931, 48703, 46341,
		43852, 41243, 38521, 35693, 32768, 29753, 26656, 23486,
		20252, 16962, 13626, 10252, 6850, 3430, 0
	};

	function automatic int cos_deg(input int deg);
		int d;
		int r;
		int sign;
		int idx;
		d = deg % 360;
		sign = 1;
		if (d <= 90) begin
			r = d;
		end else if (d <= 180) begin
			r = 180 - d;
			sign = -1;
		end else if (d < 270) begin
			r = d - 180;
			sign = -1;
		end else begin
			r = 360 - d;
		end
		idx = r / 3;
		if (idx > 30) begin
			idx = 30;
		end
		return sign * COS_Q16[idx];
	endfunction

	function automatic int tap_off(input int c, input int radius);
		int u;
		u = radius * c + radius * 65536 + 32768;
		if (u < 0) begin
			u = 0;
		end
		return (u >>> 16) - radius;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lbph_if.sv =====
// ----------------------------------------------------------------------------
// lbph_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbph_stream_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [7:0] pixel;
	logic [7:0] bin_index;
	modport source(output valid, command, pixel, bin_index, input ready);
	modport sink(input valid, command, pixel, bin_index, output ready);
endinterface

interface lbph_result_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] code;
	logic [19:0] bin_count;
	logic last_of_frame;
	modport source(output valid, kind, code, bin_count, last_of_frame, input ready);
	modport sink(input valid, kind, code, bin_count, last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/lbph_queue.sv =====
// ----------------------------------------------------------------------------
// lbph_queue
// Small register queue between the classifier and the pattern engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lbph_queue #(
	parameter int DATA_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   empty
);
	import lbph_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0] cnt_q;

	assign full = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lbph_front.sv =====
// ----------------------------------------------------------------------------
// lbph_front
// Register port, raster position tracking and classification of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbph_front #(
	parameter int MAX_WIDTH = lbph_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbph_pkg::MAX_HEIGHT_DEF,
	parameter int RADIUS = lbph_pkg::RADIUS_DEF,
	parameter int NEIGHBORS = lbph_pkg::NEIGHBORS_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lbph_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [lbph_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lbph_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	lbph_stream_if.sink                          stream,
	input  wire logic                            queue_full,
	output logic                                 push,
	output lbph_pkg::op_t                        push_op,
	output logic [COL_W-1:0]                     push_col
);
	import lbph_pkg::*;

	localparam int DIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + RADIUS + 2);
	localparam int CROW_W = $clog2(MAX_HEIGHT);
	localparam int LAG_W = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
	localparam int STEP = 360 / NEIGHBORS;

	logic [REG_W-1:0] width_q;
	logic [REG_W-1:0] height_q;
	logic [COL_W-1:0] scol_q;
	logic [ROW_W-1:0] srow_q;
	logic done_q;
	logic [LAG_W-1:0] cnt_q;
	logic [COL_W-1:0] ccol_q;
	logic [CROW_W-1:0] crow_q;

	logic [DIM_W-1:0] w_eff;
	logic [HDIM_W-1:0] h_eff;
	logic [LAG_W-1:0] lag_val;
	logic cfg_wr;
	logic acc;
	cmd_t cmd;
	logic is_read;
	logic is_reject;
	logic is_stream;
	logic emit;
	logic last;
	logic scol_last;
	logic srow_last;
	logic ccol_last;
	logic crow_last;
	logic [MAX_TAPS-1:0] mask_c;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HDIM_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = HDIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = HDIM_W'(height_q);
		end
	end

	assign lag_val = LAG_W'(int'(w_eff) * RADIUS + RADIUS);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_WIDTH: prdata = APB_DATA_W'(width_q);
			REG_HEIGHT: prdata = APB_DATA_W'(height_q);
			default: prdata = '0;
		endcase
	end

	assign stream.ready = !queue_full;
	assign acc = stream.valid && !queue_full;
	assign cmd = cmd_t'(stream.command);

	assign is_read = (cmd == CMD_READ);
	assign is_reject = (cmd == CMD_BAD) || (cmd == CMD_PIXEL && done_q)
		|| (cmd == CMD_FLUSH && !done_q);
	assign is_stream = !is_read && !is_reject;

	assign scol_last = (DIM_W'(scol_q) == w_eff - DIM_W'(1));
	assign srow_last = (srow_q == ROW_W'(h_eff) - ROW_W'(1));
	assign ccol_last = (DIM_W'(ccol_q) == w_eff - DIM_W'(1));
	assign crow_last = (HDIM_W'(crow_q) == h_eff - HDIM_W'(1));
	assign emit = (cnt_q == lag_val);
	assign last = emit && ccol_last && crow_last;

	for (genvar h = 0; h < MAX_TAPS; h++) begin : g_mask
		if (h < NEIGHBORS) begin : g_tap
			localparam int DR = tap_off(cos_deg(h * STEP), RADIUS);
			localparam int DC = tap_off(cos_deg(h * STEP + 270), RADIUS);
			assign mask_c[h] = (int'(crow_q) + DR >= 0) && (int'(crow_q) + DR < int'(h_eff))
				&& (int'(ccol_q) + DC >= 0) && (int'(ccol_q) + DC < int'(w_eff));
		end else begin : g_none
			assign mask_c[h] = 1'b0;
		end
	end

	always_comb begin
		push_op.kind = is_read ? OP_READ : (is_reject ? OP_REJECT : OP_STREAM);
		push_op.value = is_read ? stream.bin_index
			: ((cmd == CMD_PIXEL) ? stream.pixel : 8'd0);
		push_op.clear = is_stream && (cmd == CMD_PIXEL) && (srow_q == '0) && (scol_q == '0);
		push_op.emit = is_stream && emit;
		push_op.last = is_stream && last;
		push_op.mask = mask_c;
	end

	assign push = acc;
	assign push_col = scol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
			scol_q <= '0;
			srow_q <= '0;
			done_q <= 1'b0;
			cnt_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_WIDTH: width_q <= pwdata[REG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[REG_W-1:0];
				default: width_q <= width_q;
			endcase
			scol_q <= '0;
			srow_q <= '0;
			done_q <= 1'b0;
			cnt_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (acc && is_stream) begin
			if (cmd == CMD_PIXEL && srow_last && scol_last) begin
				done_q <= 1'b1;
			end
			if (scol_last) begin
				scol_q <= '0;
				srow_q <= srow_q + ROW_W'(1);
			end else begin
				scol_q <= scol_q + COL_W'(1);
			end
			if (!emit) begin
				cnt_q <= cnt_q + LAG_W'(1);
			end else if (ccol_last) begin
				ccol_q <= '0;
				crow_q <= crow_q + CROW_W'(1);
			end else begin
				ccol_q <= ccol_q + COL_W'(1);
			end
			if (last) begin
				scol_q <= '0;
				srow_q <= '0;
				done_q <= 1'b0;
				cnt_q <= '0;
				ccol_q <= '0;
				crow_q <= '0;
			end
		end
	end

	// The first pixel of a frame never completes a pattern.
	a_clear_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		acc && push_op.clear |-> !push_op.emit)
		else $error("frame start item also emits a code");

	a_done_by_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(acc && cmd == CMD_PIXEL && !cfg_wr))
		else $error("frame end flag set without an accepted pixel");

endmodule

`default_nettype wire

// ===== rtl/lbph_back.sv =====
// ----------------------------------------------------------------------------
// lbph_back
// Line memory, sampling window, pattern compare, histogram and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbph_back #(
	parameter int MAX_WIDTH = lbph_pkg::MAX_WIDTH_DEF,
	parameter int RADIUS = lbph_pkg::RADIUS_DEF,
	parameter int NEIGHBORS = lbph_pkg::NEIGHBORS_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  lbph_pkg::op_t         head_op,
	input  wire logic [COL_W-1:0] head_col,
	output logic                  pop,
	lbph_result_if.source         result
);
	import lbph_pkg::*;

	localparam int WN = 2 * RADIUS + 1;
	localparam int LINE_W = 16 * RADIUS;
	localparam int STEP = 360 / NEIGHBORS;

	logic [LINE_W-1:0] line_mem [MAX_WIDTH];
	logic [COUNT_W-1:0] hist_mem [HIST_BINS];
	logic [HIST_BINS-1:0] hvalid_q;

	logic advance;
	logic res_valid_q;
	kind_t res_kind_q;
	logic [7:0] res_code_q;
	logic [COUNT_W-1:0] res_count_q;
	logic res_last_q;

	logic v_s1;
	op_t op_s1;
	logic [COL_W-1:0] col_s1;
	logic [LINE_W-1:0] lrd_s1;
	logic lfwd_s1;
	logic [LINE_W-1:0] lfwd_data_s1;

	logic v_s2;
	op_t op_s2;
	logic [7:0] code_s2;

	logic v_s3;
	op_t op_s3;
	logic [7:0] addr_s3;
	logic [COUNT_W-1:0] hrd_s3;
	logic hval_s3;
	logic hfwd_s3;
	logic [COUNT_W-1:0] hfwd_data_s3;

	logic [7:0] win_q [WN][WN];
	logic [7:0] winn [WN][WN];
	logic [7:0] colw [WN];
	logic [LINE_W-1:0] mem_word;
	logic [LINE_W-1:0] wr_word;
	logic line_we;
	logic [7:0] code_c;
	logic [7:0] addr_s2;
	logic [COUNT_W-1:0] count_s3;
	logic [COUNT_W-1:0] hist_wdata;
	logic hist_we;
	logic clear_now;

	assign advance = !res_valid_q || result.ready;
	assign pop = advance && head_valid;

	assign line_we = v_s1 && (op_s1.kind == OP_STREAM);
	assign mem_word = lfwd_s1 ? lfwd_data_s1 : lrd_s1;

	always_comb begin
		colw[0] = op_s1.value;
		for (int j = 1; j < WN; j++) begin
			colw[j] = mem_word[8*(j-1) +: 8];
		end
		for (int j = 0; j < WN - 1; j++) begin
			wr_word[8*j +: 8] = colw[j];
		end
		winn[0] = colw;
		for (int k = 1; k < WN; k++) begin
			winn[k] = win_q[k-1];
		end
	end

	for (genvar h = 0; h < MAX_TAPS; h++) begin : g_code
		if (h < NEIGHBORS) begin : g_tap
			localparam int DR = tap_off(cos_deg(h * STEP), RADIUS);
			localparam int DC = tap_off(cos_deg(h * STEP + 270), RADIUS);
			assign code_c[h] = op_s1.mask[h] ? (winn[RADIUS-DC][RADIUS-DR] >= winn[RADIUS][RADIUS])
				: (winn[RADIUS][RADIUS] == 8'd0);
		end else begin : g_none
			assign code_c[h] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (line_we) begin
				line_mem[col_s1] <= wr_word;
			end
			lrd_s1 <= line_mem[head_col];
			lfwd_s1 <= line_we && (col_s1 == head_col);
			lfwd_data_s1 <= wr_word;
			op_s1 <= head_op;
			col_s1 <= head_col;
			if (line_we) begin
				win_q <= winn;
			end
			op_s2 <= op_s1;
			code_s2 <= code_c;
		end
	end

	assign addr_s2 = (op_s2.kind == OP_READ) ? op_s2.value : code_s2;
	assign clear_now = advance && v_s3 && (op_s3.kind == OP_STREAM) && op_s3.clear;
	assign count_s3 = hfwd_s3 ? hfwd_data_s3 : (hval_s3 ? hrd_s3 : '0);
	assign hist_wdata = (count_s3 == COUNT_MAX) ? count_s3 : count_s3 + COUNT_W'(1);
	assign hist_we = advance && v_s3 && (op_s3.kind == OP_STREAM) && op_s3.emit;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (hist_we) begin
				hist_mem[addr_s3] <= hist_wdata;
			end
			hrd_s3 <= hist_mem[addr_s2];
			hval_s3 <= hvalid_q[addr_s2] && !clear_now;
			hfwd_s3 <= hist_we && (addr_s3 == addr_s2);
			hfwd_data_s3 <= hist_wdata;
			op_s3 <= op_s2;
			addr_s3 <= addr_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
		end else if (clear_now) begin
			hvalid_q <= '0;
		end else if (hist_we) begin
			hvalid_q[addr_s3] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			res_valid_q <= v_s3 && ((op_s3.kind != OP_STREAM) || op_s3.emit);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case (op_s3.kind)
				OP_STREAM: begin
					res_kind_q <= KIND_CODE;
					res_code_q <= addr_s3;
					res_count_q <= '0;
					res_last_q <= op_s3.last;
				end
				OP_READ: begin
					res_kind_q <= KIND_COUNT;
					res_code_q <= op_s3.value;
					res_count_q <= count_s3;
					res_last_q <= 1'b0;
				end
				default: begin
					res_kind_q <= KIND_REJECT;
					res_code_q <= 8'd0;
					res_count_q <= '0;
					res_last_q <= 1'b0;
				end
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.kind = res_kind_q;
	assign result.code = res_code_q;
	assign result.bin_count = res_count_q;
	assign result.last_of_frame = res_last_q;

	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hist_we && clear_now))
		else $error("histogram clear and increment in the same cycle");

	a_res_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance && v_s3))
		else $error("result appeared without an item leaving the last stage");

endmodule

`default_nettype wire

// ===== rtl/local_binary_pattern_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// local_binary_pattern_histogram_unit
// Local binary pattern coder over a raster pixel stream with a code histogram.
// ----------------------------------------------------------------------------
// Port group   Direction  Handshake          Carries
// stream       in         valid/ready        command, pixel, bin_index
// result       out        valid/ready        kind, code, bin_count, last_of_frame
// apb          in/out     psel/penable       frame_width (0x0), frame_height (0x4)
//
// One item is accepted per clock unless the queue is full; the result register follows stage s3.
// The line memory and histogram are each one read and one write per cycle.
// Reset clears control state and histogram valid bits; no clearing pass runs.
// A stalled result freezes the back pipeline, and the input stalls once the
// four-entry queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module local_binary_pattern_histogram_unit #(
	parameter int MAX_WIDTH = lbph_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbph_pkg::MAX_HEIGHT_DEF,
	parameter int RADIUS = lbph_pkg::RADIUS_DEF,
	parameter int NEIGHBORS = lbph_pkg::NEIGHBORS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lbph_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [lbph_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lbph_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	lbph_stream_if.sink                          stream,
	lbph_result_if.source                        result
);
	import lbph_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int Q_W = $bits(op_t) + COL_W;

	logic queue_full;
	logic queue_empty;
	logic push;
	op_t push_op;
	logic [COL_W-1:0] push_col;
	logic pop;
	op_t head_op;
	logic [COL_W-1:0] head_col;
	logic [Q_W-1:0] push_data;
	logic [Q_W-1:0] pop_data;

	assign push_data = {push_op, push_col};
	assign head_op = op_t'(pop_data[Q_W-1:COL_W]);
	assign head_col = pop_data[COL_W-1:0];

	lbph_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.RADIUS(RADIUS),
		.NEIGHBORS(NEIGHBORS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.stream(stream),
		.queue_full(queue_full),
		.push(push),
		.push_op(push_op),
		.push_col(push_col)
	);

	lbph_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(queue_full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(queue_empty)
	);

	lbph_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.RADIUS(RADIUS),
		.NEIGHBORS(NEIGHBORS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!queue_empty),
		.head_op(head_op),
		.head_col(head_col),
		.pop(pop),
		.result(result)
	);

endmodule

`default_nettype wire
